// ===== hdl/sslf_pkg.sv =====
// shared types, constants and helpers for the scan segment line fit block
package sslf_pkg;

    // datapath word sizes
    localparam int WIDE_W     = 128;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int OUT_W      = 32;

    // configuration register widths
    localparam int START_W    = 10;
    localparam int END_W      = 11;
    localparam int WF_W       = 16;
    localparam int DEV_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_FACTOR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEVIATION = 2'd3;

    // reset values of the configuration registers
    localparam logic [START_W-1:0] RST_WINDOW_START  = 10'd0;
    localparam logic [END_W-1:0]   RST_WINDOW_END    = 11'd1024;
    localparam logic [WF_W-1:0]    RST_WIDTH_FACTOR  = 16'd0;
    localparam logic [DEV_W-1:0]   RST_MAX_DEVIATION = 32'd100;

    // quotient caps
    localparam logic [WORD_W-1:0] CAP_A     = 64'h0000_1000_0000_0000;
    localparam logic [WORD_W-1:0] CAP_B     = 64'h0020_0000_0000_0000;
    localparam logic [WORD_W-1:0] CAP_MSE   = 64'h0000_0000_FFFF_FFFF;
    localparam logic [WORD_W-1:0] CAP_SLOPE = 64'h0000_0000_8000_0000;

    // saturation bounds
    localparam logic signed [WORD_W-1:0] SAT_HI  = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] SAT_LO  = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [WORD_W-1:0] BIG_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WORD_W-1:0] BIG_NEG = 64'sh8000_0000_0000_0000;
    localparam logic [OUT_W-1:0] OUT_MAX  = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN  = 32'h8000_0000;
    localparam logic [OUT_W-1:0] OUT_ONES = 32'hFFFF_FFFF;

    // multiplier operations
    typedef enum logic [2:0] {
        MUL_N_SXX,
        MUL_SX_SX,
        MUL_N_SXY,
        MUL_SX_SY,
        MUL_SY_SXX,
        MUL_SX_SXY,
        MUL_ERR_SQ,
        MUL_WF_PM
    } t_mul_op;

    // divider operations
    typedef enum logic [1:0] {
        DIV_A,
        DIV_B,
        DIV_MSE,
        DIV_SLOPE
    } t_div_op;

    // controller to datapath commands
    typedef struct packed {
        logic    load_sample;
        logic    accum;
        logic    clear_scan;
        logic    mul_start;
        t_mul_op mul_op;
        logic    div_start;
        t_div_op div_op;
        logic    res_init;
        logic    res_read;
        logic    res_chk;
        logic    slope_plain;
        logic    slope_sat;
        logic    out_load;
        logic    out_fail;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_end;
        logic bad_window;
        logic n_zero;
        logic den_zero;
        logic res_end;
        logic rd_ok;
        logic wf_zero;
        logic p_zero;
        logic mul_done;
        logic div_done;
    } t_stat;

    // clamp a signed word to the signed 32-bit range
    function automatic logic [OUT_W-1:0] sat32(input logic signed [WORD_W-1:0] v);
        logic [OUT_W-1:0] res;
        if (v > SAT_HI) begin
            res = OUT_MAX;
        end else if (v < SAT_LO) begin
            res = OUT_MIN;
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/sslf_mul.sv =====
// 64 by 64 unsigned multiplier built from one 32 by 32 multiplier over four steps
module sslf_mul import sslf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic              o_done,
    output logic [WIDE_W-1:0] o_prod
);

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_step;
    logic              r_pp_vld;
    logic [1:0]        r_pp_sh;
    logic [WORD_W-1:0] r_pp;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WIDE_W-1:0] r_acc;
    logic [HALF_W-1:0] op_x;
    logic [HALF_W-1:0] op_y;
    logic [1:0]        pp_sh;
    logic [WORD_W-1:0] pp;
    logic [WIDE_W-1:0] pp_aligned;

    // pick the halves for this step
    always_comb begin
        case (r_step)
            3'd0: begin
                op_x  = r_a[HALF_W-1:0];
                op_y  = r_b[HALF_W-1:0];
                pp_sh = 2'd0;
            end
            3'd1: begin
                op_x  = r_a[HALF_W-1:0];
                op_y  = r_b[WORD_W-1:HALF_W];
                pp_sh = 2'd1;
            end
            3'd2: begin
                op_x  = r_a[WORD_W-1:HALF_W];
                op_y  = r_b[HALF_W-1:0];
                pp_sh = 2'd1;
            end
            default: begin
                op_x  = r_a[WORD_W-1:HALF_W];
                op_y  = r_b[WORD_W-1:HALF_W];
                pp_sh = 2'd2;
            end
        endcase
        pp = WORD_W'(op_x) * WORD_W'(op_y);
    end

    // align the registered partial product
    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_aligned = WIDE_W'(r_pp);
            2'd1:    pp_aligned = WIDE_W'(r_pp) << HALF_W;
            default: pp_aligned = WIDE_W'(r_pp) << WORD_W;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_pp_vld <= 1'b0;
            r_step   <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_step   <= 3'd0;
                r_pp_vld <= 1'b0;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                    r_pp_vld <= 1'b0;
                end else begin
                    r_step   <= r_step + 3'd1;
                    r_pp_vld <= 1'b1;
                end
            end
        end
    end

    // operands, partial product and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_pp_vld) begin
                r_acc <= r_acc + pp_aligned;
            end
            r_pp    <= pp;
            r_pp_sh <= pp_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/sslf_div.sv =====
// restoring 128-bit divider, one quotient bit per cycle, rounds half up and caps
module sslf_div import sslf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WIDE_W-1:0] i_num,
    input  logic [WIDE_W-1:0] i_den,
    input  logic [WORD_W-1:0] i_cap,
    output logic              o_done,
    output logic [WORD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(WIDE_W);

    logic              r_busy;
    logic              r_round;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WIDE_W-1:0] r_num;
    logic [WIDE_W-1:0] r_den;
    logic [WIDE_W-1:0] r_rem;
    logic [WIDE_W-1:0] r_quo;
    logic [WORD_W-1:0] r_cap;
    logic [WORD_W-1:0] r_res;
    logic [WIDE_W-1:0] rem_sh;
    logic              fits;
    logic              round_up;
    logic [WIDE_W:0]   quo_rnd;
    logic              over;

    // one restoring step and the final rounding
    always_comb begin
        rem_sh   = {r_rem[WIDE_W-2:0], r_num[WIDE_W-1]};
        fits     = rem_sh >= r_den;
        round_up = {r_rem, 1'b0} >= {1'b0, r_den};
        quo_rnd  = {1'b0, r_quo} + (WIDE_W+1)'(round_up);
        over     = quo_rnd > (WIDE_W+1)'(r_cap);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDE_W - 1)) begin
                    r_busy  <= 1'b0;
                    r_round <= 1'b1;
                end
            end else if (r_round) begin
                r_round <= 1'b0;
                r_done  <= 1'b1;
            end
        end
    end

    // operands, remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_cap <= i_cap;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - r_den) : rem_sh;
            r_quo <= {r_quo[WIDE_W-2:0], fits};
            r_num <= {r_num[WIDE_W-2:0], 1'b0};
        end else if (r_round) begin
            r_res <= over ? r_cap : quo_rnd[WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule

// ===== hdl/sslf_dpath.sv =====
// datapath: sample store, running sums, fit arithmetic and result registers
module sslf_dpath import sslf_pkg::*; #(
    parameter int MAX_SCAN    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [SAMPLE_BITS-1:0] i_distance,
    input  logic                   i_sample_ok,
    input  logic                   i_scan_end,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic                   o_failed,
    output logic signed [OUT_W-1:0] o_slope,
    output logic signed [OUT_W-1:0] o_intercept,
    output logic [OUT_W-1:0]       o_mean_sq_error,
    output logic                   o_straight
);

    localparam int AW   = $clog2(MAX_SCAN);
    localparam int CW   = $clog2(MAX_SCAN + 1);
    localparam int CMPW = (CW > END_W) ? CW : END_W;
    localparam int MW   = SAMPLE_BITS + 1;
    localparam int SXW  = AW + CW;
    localparam int SYW  = SAMPLE_BITS + CW;
    localparam int SXYW = SAMPLE_BITS + AW + CW;
    localparam int SXXW = 2 * AW + CW;
    localparam int XYW  = AW + SAMPLE_BITS;
    localparam int XXW  = 2 * AW;

    // configuration
    logic [START_W-1:0] r_win_start;
    logic [END_W-1:0]   r_win_end;
    logic [WF_W-1:0]    r_width_factor;
    logic [DEV_W-1:0]   r_max_dev;

    // scan state
    logic [CW-1:0]   r_pos;
    logic [CW-1:0]   r_n;
    logic [SXW-1:0]  r_sx;
    logic [SYW-1:0]  r_sy;
    logic [SXYW-1:0] r_sxy;
    logic [SXXW-1:0] r_sxx;

    // captured sample
    logic [SAMPLE_BITS-1:0] r_samp_dist;
    logic                   r_samp_ok;
    logic                   r_samp_end;

    // sample store
    logic [MW-1:0] r_mem [MAX_SCAN];
    logic [MW-1:0] r_rd_data;

    // fit arithmetic
    logic [WIDE_W-1:0]        r_tmp;
    logic [WIDE_W-1:0]        r_den;
    logic [WIDE_W-1:0]        r_num;
    logic                     r_neg;
    logic [WIDE_W-1:0]        r_sq;
    logic signed [WORD_W-1:0] r_a;
    logic signed [WORD_W-1:0] r_b;
    logic signed [WORD_W-1:0] r_pred;
    logic signed [WORD_W-1:0] r_slope;
    logic [WORD_W-1:0]        r_err;
    logic [CW-1:0]            r_idx;
    logic [OUT_W-1:0]         r_mse;
    t_mul_op                  r_mul_op;
    t_div_op                  r_div_op;

    // result registers
    logic                    r_failed;
    logic [OUT_W-1:0]        r_slope_out;
    logic [OUT_W-1:0]        r_icpt_out;
    logic [OUT_W-1:0]        r_mse_out;
    logic                    r_straight;

    logic [CMPW-1:0]          pos_cmp;
    logic [CMPW-1:0]          ws_cmp;
    logic [CMPW-1:0]          we_cmp;
    logic                     room;
    logic                     in_win;
    logic [AW-1:0]            x;
    logic [XYW-1:0]           xy;
    logic [XXW-1:0]           xx;
    logic signed [WORD_W-1:0] y_q;
    logic signed [WORD_W-1:0] err;
    logic [WORD_W-1:0]        err_mag;
    logic [WORD_W-1:0]        a_mag;
    logic [WORD_W-1:0]        p_mag;
    logic [WORD_W-1:0]        mul_a;
    logic [WORD_W-1:0]        mul_b;
    logic                     mul_done;
    logic [WIDE_W-1:0]        mul_prod;
    logic [WIDE_W-1:0]        div_num;
    logic [WIDE_W-1:0]        div_den;
    logic [WORD_W-1:0]        div_cap;
    logic                     div_done;
    logic [WORD_W-1:0]        div_quot;
    logic signed [WORD_W-1:0] quot_s;

    // window and sample terms
    always_comb begin
        pos_cmp = CMPW'(r_pos);
        ws_cmp  = CMPW'(r_win_start);
        we_cmp  = CMPW'(r_win_end);
        room    = r_pos < CW'(MAX_SCAN);
        in_win  = r_samp_ok && (pos_cmp >= ws_cmp) && (pos_cmp < we_cmp);
        x       = AW'(pos_cmp - ws_cmp);
        xy      = XYW'(x) * XYW'(r_samp_dist);
        xx      = XXW'(x) * XXW'(x);
    end

    // residual of one stored sample against the running prediction
    always_comb begin
        y_q     = $signed(WORD_W'({r_rd_data[SAMPLE_BITS-1:0], FRAC_W'(0)}));
        err     = y_q - r_pred;
        err_mag = err[WORD_W-1] ? (WORD_W'(0) - WORD_W'(err)) : WORD_W'(err);
        a_mag   = r_a[WORD_W-1] ? (WORD_W'(0) - WORD_W'(r_a)) : WORD_W'(r_a);
        p_mag   = r_pred[WORD_W-1] ? (WORD_W'(0) - WORD_W'(r_pred)) : WORD_W'(r_pred);
        quot_s  = $signed(div_quot);
    end

    // multiplier operand select
    always_comb begin
        case (i_cmd.mul_op)
            MUL_N_SXX: begin
                mul_a = WORD_W'(r_n);
                mul_b = WORD_W'(r_sxx);
            end
            MUL_SX_SX: begin
                mul_a = WORD_W'(r_sx);
                mul_b = WORD_W'(r_sx);
            end
            MUL_N_SXY: begin
                mul_a = WORD_W'(r_n);
                mul_b = WORD_W'(r_sxy);
            end
            MUL_SX_SY: begin
                mul_a = WORD_W'(r_sx);
                mul_b = WORD_W'(r_sy);
            end
            MUL_SY_SXX: begin
                mul_a = WORD_W'(r_sy);
                mul_b = WORD_W'(r_sxx);
            end
            MUL_SX_SXY: begin
                mul_a = WORD_W'(r_sx);
                mul_b = WORD_W'(r_sxy);
            end
            MUL_ERR_SQ: begin
                mul_a = r_err;
                mul_b = r_err;
            end
            MUL_WF_PM: begin
                mul_a = WORD_W'(r_width_factor);
                mul_b = p_mag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operand select
    always_comb begin
        case (i_cmd.div_op)
            DIV_A: begin
                div_num = {r_num[WIDE_W-FRAC_W-1:0], FRAC_W'(0)};
                div_den = r_den;
                div_cap = CAP_A;
            end
            DIV_B: begin
                div_num = {r_num[WIDE_W-FRAC_W-1:0], FRAC_W'(0)};
                div_den = r_den;
                div_cap = CAP_B;
            end
            DIV_MSE: begin
                div_num = r_sq;
                div_den = WIDE_W'(r_n) << HALF_W;
                div_cap = CAP_MSE;
            end
            DIV_SLOPE: begin
                div_num = WIDE_W'(a_mag) << HALF_W;
                div_den = r_den;
                div_cap = CAP_SLOPE;
            end
            default: begin
                div_num = '0;
                div_den = '0;
                div_cap = '0;
            end
        endcase
    end

    sslf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    sslf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_cap   (div_cap),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration writes and scan accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start    <= RST_WINDOW_START;
            r_win_end      <= RST_WINDOW_END;
            r_width_factor <= RST_WIDTH_FACTOR;
            r_max_dev      <= RST_MAX_DEVIATION;
            r_pos          <= '0;
            r_n            <= '0;
            r_sx           <= '0;
            r_sy           <= '0;
            r_sxy          <= '0;
            r_sxx          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_WINDOW_START:  r_win_start    <= i_cfg_wdata[START_W-1:0];
                    CFG_WINDOW_END:    r_win_end      <= i_cfg_wdata[END_W-1:0];
                    CFG_WIDTH_FACTOR:  r_width_factor <= i_cfg_wdata[WF_W-1:0];
                    CFG_MAX_DEVIATION: r_max_dev      <= i_cfg_wdata[DEV_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear_scan) begin
                r_pos <= '0;
                r_n   <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxy <= '0;
                r_sxx <= '0;
            end else if (i_cmd.accum && room) begin
                r_pos <= r_pos + 1'b1;
                if (in_win) begin
                    r_n   <= r_n + 1'b1;
                    r_sx  <= r_sx + SXW'(x);
                    r_sy  <= r_sy + SYW'(r_samp_dist);
                    r_sxy <= r_sxy + SXYW'(xy);
                    r_sxx <= r_sxx + SXXW'(xx);
                end
            end
        end
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && room) begin
            r_mem[r_pos[AW-1:0]] <= {r_samp_ok, r_samp_dist};
        end
        if (i_cmd.res_read) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // sample capture, fit arithmetic and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_samp_dist <= i_distance;
            r_samp_ok   <= i_sample_ok;
            r_samp_end  <= i_scan_end;
        end
        if (i_cmd.mul_start) begin
            r_mul_op <= i_cmd.mul_op;
        end
        if (i_cmd.div_start) begin
            r_div_op <= i_cmd.div_op;
        end

        // products land by operation
        if (mul_done) begin
            case (r_mul_op)
                MUL_SX_SX: r_den <= r_tmp - mul_prod;
                MUL_SX_SY, MUL_SX_SXY: begin
                    if (r_tmp >= mul_prod) begin
                        r_num <= r_tmp - mul_prod;
                        r_neg <= 1'b0;
                    end else begin
                        r_num <= mul_prod - r_tmp;
                        r_neg <= 1'b1;
                    end
                end
                MUL_ERR_SQ: r_sq  <= r_sq + mul_prod;
                MUL_WF_PM:  r_den <= mul_prod;
                default:    r_tmp <= mul_prod;
            endcase
        end

        // quotients land by operation
        if (div_done) begin
            case (r_div_op)
                DIV_A:   r_a   <= r_neg ? -quot_s : quot_s;
                DIV_B:   r_b   <= r_neg ? -quot_s : quot_s;
                DIV_MSE: r_mse <= div_quot[OUT_W-1:0];
                default: r_slope <= (r_a[WORD_W-1] ^ r_pred[WORD_W-1]) ? -quot_s : quot_s;
            endcase
        end

        // residual pass
        if (i_cmd.res_init) begin
            r_idx  <= CW'(r_win_start);
            r_pred <= r_b;
            r_sq   <= '0;
        end
        if (i_cmd.res_chk) begin
            r_err  <= err_mag;
            r_pred <= r_pred + r_a;
            r_idx  <= r_idx + 1'b1;
        end

        // slope without division
        if (i_cmd.slope_plain) begin
            r_slope <= r_a;
        end
        if (i_cmd.slope_sat) begin
            if (r_a > 0) begin
                r_slope <= BIG_POS;
            end else if (r_a < 0) begin
                r_slope <= BIG_NEG;
            end else begin
                r_slope <= '0;
            end
        end

        // result
        if (i_cmd.out_load) begin
            if (i_cmd.out_fail) begin
                r_failed    <= 1'b1;
                r_slope_out <= '0;
                r_icpt_out  <= '0;
                r_mse_out   <= OUT_ONES;
                r_straight  <= 1'b0;
            end else begin
                r_failed    <= 1'b0;
                r_slope_out <= sat32(r_slope);
                r_icpt_out  <= sat32(r_b);
                r_mse_out   <= r_mse;
                r_straight  <= r_mse <= r_max_dev;
            end
        end
    end

    // status
    always_comb begin
        o_stat.scan_end   = r_samp_end;
        o_stat.bad_window = (we_cmp > pos_cmp) || (ws_cmp >= we_cmp) || (ws_cmp >= pos_cmp);
        o_stat.n_zero     = r_n == '0;
        o_stat.den_zero   = r_den == '0;
        o_stat.res_end    = CMPW'(r_idx) >= we_cmp;
        o_stat.rd_ok      = r_rd_data[SAMPLE_BITS];
        o_stat.wf_zero    = r_width_factor == '0;
        o_stat.p_zero     = r_pred == '0;
        o_stat.mul_done   = mul_done;
        o_stat.div_done   = div_done;
    end

    assign o_failed        = r_failed;
    assign o_slope         = $signed(r_slope_out);
    assign o_intercept     = $signed(r_icpt_out);
    assign o_mean_sq_error = r_mse_out;
    assign o_straight      = r_straight;

endmodule

// ===== hdl/sslf_ctrl.sv =====
// controller: sample intake handshake and end-of-scan fit sequencing
module sslf_ctrl import sslf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ACCUM,
        S_CHECK,
        S_D1,
        S_D2,
        S_DZ,
        S_A1,
        S_A2,
        S_ADS,
        S_ADIV,
        S_B1,
        S_B2,
        S_BDS,
        S_BDIV,
        S_RINIT,
        S_RREAD,
        S_RCHK,
        S_RMUL,
        S_RWAIT,
        S_MDIV,
        S_WADJ,
        S_W1,
        S_WDS,
        S_WDIV,
        S_OUT,
        S_FAIL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;
    t_cmd   cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_sample = 1'b1;
                    n_state         = S_ACCUM;
                end
            end
            S_ACCUM: begin
                cmd.accum = 1'b1;
                n_state   = i_stat.scan_end ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                if (i_stat.bad_window || i_stat.n_zero) begin
                    n_state = S_FAIL;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_N_SXX;
                    n_state       = S_D1;
                end
            end
            S_D1: begin
                if (i_stat.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_SX_SX;
                    n_state       = S_D2;
                end
            end
            S_D2: begin
                if (i_stat.mul_done) begin
                    n_state = S_DZ;
                end
            end
            S_DZ: begin
                if (i_stat.den_zero) begin
                    n_state = S_FAIL;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_N_SXY;
                    n_state       = S_A1;
                end
            end
            S_A1: begin
                if (i_stat.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_SX_SY;
                    n_state       = S_A2;
                end
            end
            S_A2: begin
                if (i_stat.mul_done) begin
                    n_state = S_ADS;
                end
            end
            S_ADS: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_A;
                n_state       = S_ADIV;
            end
            S_ADIV: begin
                if (i_stat.div_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_SY_SXX;
                    n_state       = S_B1;
                end
            end
            S_B1: begin
                if (i_stat.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_SX_SXY;
                    n_state       = S_B2;
                end
            end
            S_B2: begin
                if (i_stat.mul_done) begin
                    n_state = S_BDS;
                end
            end
            S_BDS: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_B;
                n_state       = S_BDIV;
            end
            S_BDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                cmd.res_init = 1'b1;
                n_state      = S_RREAD;
            end
            S_RREAD: begin
                if (i_stat.res_end) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_MSE;
                    n_state       = S_MDIV;
                end else begin
                    cmd.res_read = 1'b1;
                    n_state      = S_RCHK;
                end
            end
            S_RCHK: begin
                cmd.res_chk = 1'b1;
                n_state     = i_stat.rd_ok ? S_RMUL : S_RREAD;
            end
            S_RMUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MUL_ERR_SQ;
                n_state       = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_stat.mul_done) begin
                    n_state = S_RREAD;
                end
            end
            S_MDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_WADJ;
                end
            end
            S_WADJ: begin
                if (i_stat.wf_zero) begin
                    cmd.slope_plain = 1'b1;
                    n_state         = S_OUT;
                end else if (i_stat.p_zero) begin
                    cmd.slope_sat = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_WF_PM;
                    n_state       = S_W1;
                end
            end
            S_W1: begin
                if (i_stat.mul_done) begin
                    n_state = S_WDS;
                end
            end
            S_WDS: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_SLOPE;
                n_state       = S_WDIV;
            end
            S_WDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.clear_scan = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FAIL: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_fail   = 1'b1;
                    cmd.clear_scan = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== hdl/scan_segment_line_fit_core.sv =====
// least-squares line fit over a window of a range scan, one sample per transaction
// each sample transaction is captured, then stored and added to the scan sums
// on the final sample the fit runs on the 4-step shared multiplier and the divider; its
// run time grows with the window length W and the number V of valid samples in it
// one result per scan; a waiting result holds off samples only once the next fit is done
// synchronous active-low reset clears the scan sums and controller and loads the configuration reset values
module scan_segment_line_fit_core import sslf_pkg::*; #(
    parameter int MAX_SCAN    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SAMPLE_BITS-1:0]  i_distance,
    input  logic                    i_sample_ok,
    input  logic                    i_scan_end,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_failed,
    output logic signed [OUT_W-1:0] o_slope,
    output logic signed [OUT_W-1:0] o_intercept,
    output logic [OUT_W-1:0]        o_mean_sq_error,
    output logic                    o_straight,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    sslf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // storage and arithmetic
    sslf_dpath #(
        .MAX_SCAN    (MAX_SCAN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_distance      (i_distance),
        .i_sample_ok     (i_sample_ok),
        .i_scan_end      (i_scan_end),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_failed        (o_failed),
        .o_slope         (o_slope),
        .o_intercept     (o_intercept),
        .o_mean_sq_error (o_mean_sq_error),
        .o_straight      (o_straight)
    );

endmodule
